// ===== sv/nwt_pkg.sv =====
// Shared types, constants and helpers of the nearest waypoint tracker.
`default_nettype none
package nwt_pkg;

  localparam int IDX_W     = 12;
  localparam int LEN_W     = 13;
  localparam int STEP_W    = 12;
  localparam int REINIT_W  = 40;
  localparam int DIST_W    = 64;
  localparam int LAP_W     = 16;
  localparam int HEAD_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int S_DATA_W  = 112;
  localparam int M_DATA_W  = 96;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_SIZE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INDEX_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REINIT_DIST_SQ = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_POSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_WIN_WAIT,
    ST_CHECK,
    ST_GLOB,
    ST_GLOB_WAIT,
    ST_STAB
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic clr_best;
    logic init_win;
    logic init_glob;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic path_empty;
    logic initialized;
    logic last_issue;
    logic busy;
    logic far;
    logic out_free;
  } stat_t;

  // floor(x / 10), exact for every 16-bit x
  function automatic logic [15:0] div10(input logic [15:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'd52429;
    return 16'(p >> 19);
  endfunction

endpackage
`default_nettype wire

// ===== sv/nearest_waypoint_tracker_core.sv =====
// Top level of the nearest waypoint tracker.
// Holds a closed path of up to MAX_POINTS points and tracks the nearest one to
// the vehicle. A load request (tuser 0) writes one point; tlast on it sets the
// path length and restarts tracking. A pose request (tuser 1) streams
// candidates through a four-stage distance pipeline, one stored point per cycle
// from the single read port of the path memory. Tracking reads the window size
// + 1 points from the current index, drains the pipeline and checks the
// distance; a relocation then searches all path_length points. Before the
// first fix only the full search runs. A commit follows, and the result is
// valid in the cycle after it. One pose is worked on at a time; the finished
// result waits in an output register, and the next result is not committed
// until it is taken.
`default_nettype none
module nearest_waypoint_tracker_core #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 32
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_index[11:0], pos_x[43:12], pos_y[75:44], heading_cos[91:76],
  // heading_sin[107:92], zero fill
  input  wire [nwt_pkg::S_DATA_W-1:0]       s_axis_tdata,
  input  wire                               s_axis_tlast,   // last_point
  input  wire                               s_axis_tuser,   // action
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // waypoint_index[11:0], lap_total[27:12], lap_completed[28], relocated[29],
  // forward_found[30], nearest_dist_sq[94:31], zero fill
  output logic [nwt_pkg::M_DATA_W-1:0]      m_axis_tdata,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [nwt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [nwt_pkg::REINIT_W-1:0]       cfg_data_i
);
  import nwt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  nwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_action_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nwt_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .s_data_i    (s_axis_tdata),
    .s_last_i    (s_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ===== sv/nwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nwt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/nwt_ctrl.sv =====
// Sequencing state machine of the nearest waypoint tracker.
`default_nettype none
module nwt_ctrl (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           s_valid_i,
  input  wire           s_action_i,
  output logic          s_ready_o,
  input  nwt_pkg::stat_t stat_i,
  output nwt_pkg::cmd_t  cmd_o
);
  import nwt_pkg::*;

  state_e state_q, state_d;
  logic   s_fire;
  logic   pose_go;

  assign s_fire  = s_valid_i && s_ready_o;
  assign pose_go = s_fire && (s_action_i == ACT_POSE) && !stat_i.path_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pose_go) begin
          state_d = stat_i.initialized ? ST_WIN : ST_GLOB;
        end
      end
      ST_WIN: begin
        if (stat_i.last_issue) state_d = ST_WIN_WAIT;
      end
      ST_WIN_WAIT: begin
        if (!stat_i.busy) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = stat_i.far ? ST_GLOB : ST_STAB;
      end
      ST_GLOB: begin
        if (stat_i.last_issue) state_d = ST_GLOB_WAIT;
      end
      ST_GLOB_WAIT: begin
        if (!stat_i.busy) state_d = ST_STAB;
      end
      ST_STAB: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o       = 1'b1;
        cmd_o.load      = s_fire && (s_action_i == ACT_LOAD);
        cmd_o.start     = pose_go;
        cmd_o.clr_best  = pose_go;
        cmd_o.init_win  = pose_go && stat_i.initialized;
        cmd_o.init_glob = pose_go && !stat_i.initialized;
      end
      ST_WIN, ST_GLOB: begin
        cmd_o.issue = 1'b1;
      end
      ST_CHECK: begin
        cmd_o.clr_best  = stat_i.far;
        cmd_o.init_glob = stat_i.far;
      end
      ST_STAB: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/nwt_datapath.sv =====
// Path store, distance pipeline, best-candidate tracking and index stabilization.
`default_nettype none
module nwt_datapath #(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 32
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  nwt_pkg::cmd_t                        cmd_i,
  output nwt_pkg::stat_t                       stat_o,
  input  wire [nwt_pkg::S_DATA_W-1:0]          s_data_i,
  input  wire                                  s_last_i,
  input  wire                                  cfg_valid_i,
  input  wire [nwt_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [nwt_pkg::REINIT_W-1:0]          cfg_data_i,
  output logic                                 m_valid_o,
  input  wire                                  m_ready_i,
  output logic [nwt_pkg::M_DATA_W-1:0]         m_data_o
);
  import nwt_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int SQW = 2 * DW;
  localparam int PW  = DW + HEAD_W;

  // request fields
  logic [IDX_W-1:0]         in_idx;
  logic signed [CW-1:0]     in_x, in_y;
  logic signed [HEAD_W-1:0] in_hc, in_hs;
  logic                     in_range;

  assign in_idx   = s_data_i[11:0];
  assign in_x     = s_data_i[12 +: CW];
  assign in_y     = s_data_i[44 +: CW];
  assign in_hc    = s_data_i[91:76];
  assign in_hs    = s_data_i[107:92];
  assign in_range = 17'(in_idx) < 17'(MAX_POINTS);

  // configuration
  logic [STEP_W-1:0]   win_q, step_q;
  logic [REINIT_W-1:0] reinit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= 12'd150;
      step_q   <= 12'd20;
      reinit_q <= 40'd4194304;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIN_SIZE:       win_q    <= cfg_data_i[STEP_W-1:0];
        CFG_MAX_INDEX_STEP: step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_REINIT_DIST_SQ: reinit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // tracker state
  logic [LEN_W-1:0] len_q;
  logic [IDX_W-1:0] cur_q;
  logic             init_q;
  logic [LAP_W-1:0] lap_q;
  logic             glob_q;

  // pose and thresholds
  logic signed [CW-1:0]     vx_q, vy_q;
  logic signed [HEAD_W-1:0] hc_q, hs_q;
  logic [LEN_W-1:0]         hi_q, lo_q;
  logic [15:0]              len9;

  assign len9 = {len_q, 3'b000} + 16'(len_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      vx_q <= in_x;
      vy_q <= in_y;
      hc_q <= in_hc;
      hs_q <= in_hs;
      hi_q <= LEN_W'(div10(len9));
      lo_q <= LEN_W'(div10(16'(len_q)));
    end
  end

  // candidate address generator
  logic [IDX_W-1:0] addr_q, cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_win) begin
      addr_q <= cur_q;
      cnt_q  <= win_q;
    end else if (cmd_i.init_glob) begin
      addr_q <= '0;
      cnt_q  <= IDX_W'(len_q - 13'd1);
    end else if (cmd_i.issue) begin
      addr_q <= (LEN_W'(addr_q) == len_q - 13'd1) ? '0 : addr_q + 12'd1;
      if (cnt_q != '0) cnt_q <= cnt_q - 12'd1;
    end
  end

  // path store
  logic [2*CW-1:0] rdata;

  nwt_ram #(
    .WIDTH(2 * CW),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && in_range),
    .waddr_i (AW'(in_idx)),
    .wdata_i ({in_y, in_x}),
    .re_i    (cmd_i.issue),
    .raddr_i (AW'(addr_q)),
    .rdata_o (rdata)
  );

  // distance pipeline
  logic             v1_q, v2_q, v3_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [DW-1:0]        ax, ay;
  logic [SQW-1:0]       sqx_q, sqy_q;
  logic signed [PW-1:0] px_q, py_q;
  logic signed [CW-1:0] rx, ry;

  assign rx = rdata[CW-1:0];
  assign ry = rdata[2*CW-1:CW];
  assign ax = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
  assign ay = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= addr_q;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    dx_q   <= DW'(rx) - DW'(vx_q);
    dy_q   <= DW'(ry) - DW'(vy_q);
    sqx_q  <= SQW'(ax) * SQW'(ax);
    sqy_q  <= SQW'(ay) * SQW'(ay);
    px_q   <= PW'(dx_q) * PW'(hc_q);
    py_q   <= PW'(dy_q) * PW'(hs_q);
  end

  // best candidates
  logic [65:0]          sum;
  logic [DIST_W-1:0]    cand_d;
  logic signed [PW:0]   dot;
  logic                 ahead;
  logic                 any_ok_q, fwd_ok_q;
  logic [DIST_W-1:0]    any_d_q, fwd_d_q;
  logic [IDX_W-1:0]     any_i_q, fwd_i_q;

  assign sum    = 66'(sqx_q) + 66'(sqy_q);
  assign cand_d = (|sum[65:64]) ? '1 : sum[DIST_W-1:0];
  assign dot    = (PW+1)'(px_q) + (PW+1)'(py_q);
  assign ahead  = !dot[PW] && (|dot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_ok_q <= 1'b0;
      fwd_ok_q <= 1'b0;
    end else if (cmd_i.clr_best) begin
      any_ok_q <= 1'b0;
      fwd_ok_q <= 1'b0;
    end else if (v3_q) begin
      if (!any_ok_q || cand_d < any_d_q) any_ok_q <= 1'b1;
      if (ahead && (!fwd_ok_q || cand_d < fwd_d_q)) fwd_ok_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && !cmd_i.clr_best) begin
      if (!any_ok_q || cand_d < any_d_q) begin
        any_d_q <= cand_d;
        any_i_q <= idx3_q;
      end
      if (ahead && (!fwd_ok_q || cand_d < fwd_d_q)) begin
        fwd_d_q <= cand_d;
        fwd_i_q <= idx3_q;
      end
    end
  end

  logic [DIST_W-1:0] min_d;
  logic [IDX_W-1:0]  best;

  assign min_d = fwd_ok_q ? fwd_d_q : any_d_q;
  assign best  = fwd_ok_q ? fwd_i_q : any_i_q;

  // stabilization
  logic [LEN_W-1:0] fwd_dl, bwd_dl, pv, bs, clamp_s;
  logic             wrap, lap;
  logic [IDX_W-1:0] nxt;

  assign pv      = LEN_W'(cur_q);
  assign bs      = LEN_W'(best);
  assign fwd_dl  = (bs >= pv) ? bs - pv : bs + len_q - pv;
  assign bwd_dl  = (pv >= bs) ? pv - bs : pv + len_q - bs;
  assign wrap    = (pv > hi_q) && (bs < lo_q);
  assign clamp_s = pv + LEN_W'(step_q);

  always_comb begin
    if (!wrap && bwd_dl < fwd_dl) begin
      nxt = cur_q;
    end else if (fwd_dl > LEN_W'(step_q) && 64'(min_d) < 64'(reinit_q)) begin
      nxt = IDX_W'((clamp_s >= len_q) ? clamp_s - len_q : clamp_s);
    end else begin
      nxt = best;
    end
  end

  assign lap = (nxt < cur_q) && (pv > hi_q) && (LEN_W'(nxt) < lo_q);

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      cur_q  <= '0;
      init_q <= 1'b0;
      lap_q  <= '0;
      glob_q <= 1'b0;
    end else begin
      if (cmd_i.load && in_range && s_last_i) begin
        len_q  <= LEN_W'(in_idx) + 13'd1;
        init_q <= 1'b0;
        cur_q  <= '0;
      end
      if (cmd_i.start) glob_q <= 1'b0;
      if (cmd_i.init_glob) glob_q <= 1'b1;
      if (cmd_i.commit) begin
        cur_q  <= nxt;
        init_q <= 1'b1;
        if (lap && lap_q != '1) lap_q <= lap_q + 16'd1;
      end
    end
  end

  // result register
  logic [LAP_W-1:0] lap_next;

  assign lap_next = (lap && lap_q != '1) ? lap_q + 16'd1 : lap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_o <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_o <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_data_o <= {1'b0, min_d, fwd_ok_q, glob_q, lap, lap_next, nxt};
    end
  end

  assign stat_o.path_empty  = (len_q == '0);
  assign stat_o.initialized = init_q;
  assign stat_o.last_issue  = (cnt_q == '0);
  assign stat_o.busy        = v1_q || v2_q || v3_q;
  assign stat_o.far         = 64'(min_d) > 64'(reinit_q);
  assign stat_o.out_free    = !m_valid_o || m_ready_i;

endmodule
`default_nettype wire
